FILE: rtl/regex_pattern_tokenizer_defines.svh
// Assertion macros used by the checker file of the tokenizer.
`ifndef REGEX_PATTERN_TOKENIZER_DEFINES_SVH
`define REGEX_PATTERN_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define RPT_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define RPT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("tokenizer check failed");

`endif

FILE: rtl/rpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

  // Width of the byte position counter, and of the position port.
  localparam int PosBits    = 32;
  localparam int OutPosBits = 32;

  // Most results that one request can cause.
  localparam int MaxTokens = 3;

  // Token kinds.
  typedef enum logic [4:0] {
    KindEof       = 5'd0,
    KindLParen    = 5'd1,
    KindNcGroup   = 5'd2,
    KindAlt       = 5'd3,
    KindRParen    = 5'd4,
    KindStar      = 5'd5,
    KindPlus      = 5'd6,
    KindDash      = 5'd7,
    KindQuestion  = 5'd8,
    KindDot       = 5'd9,
    KindLBracket  = 5'd10,
    KindRBracket  = 5'd11,
    KindCaret     = 5'd12,
    KindWord      = 5'd13,
    KindNotWord   = 5'd14,
    KindDigit     = 5'd15,
    KindNotDigit  = 5'd16,
    KindSpace     = 5'd17,
    KindNotSpace  = 5'd18,
    KindSpecial   = 5'd19,
    KindLiteral   = 5'd20,
    KindErrTrail  = 5'd21,
    KindErrEscape = 5'd22,
    KindErrByte   = 5'd23
  } kind_e;

  // Pending codes: what part of a multi-byte token is held back.
  localparam logic [1:0] PendNone   = 2'd0;
  localparam logic [1:0] PendParen  = 2'd1;
  localparam logic [1:0] PendQuest  = 2'd2;
  localparam logic [1:0] PendEscape = 2'd3;

  // Characters the decoder looks for.
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChDash      = 8'h2D;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChLBracket  = 8'h5B;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChRBracket  = 8'h5D;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChBar       = 8'h7C;
  localparam logic [7:0] ChUpperD    = 8'h44;
  localparam logic [7:0] ChUpperS    = 8'h53;
  localparam logic [7:0] ChUpperW    = 8'h57;
  localparam logic [7:0] ChLowerD    = 8'h64;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerS    = 8'h73;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerW    = 8'h77;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChPrintLo   = 8'h20;
  localparam logic [7:0] ChPrintHi   = 8'h7E;

  typedef logic [PosBits-1:0] pos_t;

  // One result token.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    pos_t       pos;
  } tok_t;

  // Decode of a byte outside any escape or held group.
  typedef struct packed {
    logic       emit;
    kind_e      kind;
    logic [7:0] payload;
    logic [1:0] mode;
    logic       halt;
  } fresh_t;

  // Decode of the byte after a backslash.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    logic       halt;
  } esc_t;

  function automatic fresh_t fresh_decode(input logic [7:0] b);
    fresh_t f;
    f.emit    = 1'b1;
    f.kind    = KindLiteral;
    f.payload = 8'd0;
    f.mode    = PendNone;
    f.halt    = 1'b0;
    unique case (b)
      ChLParen: begin
        f.emit = 1'b0;
        f.mode = PendParen;
      end
      ChBackslash: begin
        f.emit = 1'b0;
        f.mode = PendEscape;
      end
      ChBar:      f.kind = KindAlt;
      ChRParen:   f.kind = KindRParen;
      ChStar:     f.kind = KindStar;
      ChPlus:     f.kind = KindPlus;
      ChDash:     f.kind = KindDash;
      ChQuestion: f.kind = KindQuestion;
      ChDot:      f.kind = KindDot;
      ChLBracket: f.kind = KindLBracket;
      ChRBracket: f.kind = KindRBracket;
      ChCaret:    f.kind = KindCaret;
      default: begin
        if (b >= ChPrintLo && b <= ChPrintHi) begin
          f.kind    = KindLiteral;
          f.payload = b;
        end else begin
          f.kind = KindErrByte;
          f.halt = 1'b1;
        end
      end
    endcase
    return f;
  endfunction

  function automatic esc_t esc_decode(input logic [7:0] b);
    esc_t e;
    e.kind    = KindSpecial;
    e.payload = 8'd0;
    e.halt    = 1'b0;
    unique case (b)
      ChLowerW: e.kind = KindWord;
      ChUpperW: e.kind = KindNotWord;
      ChLowerD: e.kind = KindDigit;
      ChUpperD: e.kind = KindNotDigit;
      ChLowerS: e.kind = KindSpace;
      ChUpperS: e.kind = KindNotSpace;
      ChLowerT: e.payload = ChTab;
      ChLowerN: e.payload = ChNewline;
      ChLowerR: e.payload = ChReturn;
      ChDot, ChStar, ChPlus, ChQuestion, ChLParen, ChRParen,
      ChLBracket, ChRBracket, ChBar, ChCaret, ChBackslash: e.payload = b;
      default: begin
        e.kind = KindErrEscape;
        e.halt = 1'b1;
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/regex_pattern_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake               Payload
// input    in         in_valid_i/in_stall_o   op_i, pattern_byte_i
// output   out        out_valid_o/out_stall_i kind_o, payload_o, position_o, last_o
//
// A registered request is decoded in one pass into a result bundle of zero to three
// tokens. Unless stalled, a new request can enter every cycle, and the output port
// sends one token a cycle; a request with k > 1 results keeps the next in the input
// register until its last token leaves, so the single output port sets the rate.
// The input register takes a request while the bundle still waits on a stall.
// Reset clears the held group, the byte counter, the error halt and all valids.
module regex_pattern_tokenizer
  import rpt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic [7:0]            pattern_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [4:0]                 kind_o,
  output logic [7:0]                 payload_o,
  output logic [OutPosBits-1:0]      position_o,
  output logic                       last_o
);

  // Input register.
  logic       inq_valid_q, inq_valid_d;
  logic       inq_op_q;
  logic [7:0] inq_byte_q;

  // Tokenizer state.
  logic [1:0] mode_q, mode_d;
  pos_t       count_q, count_d;
  logic       halted_q, halted_d;

  // Result bundle, drained from slot 0.
  tok_t       tok_q [MaxTokens];
  tok_t       tok_d [MaxTokens];
  logic [1:0] cnt_q, cnt_d;

  logic in_fire, out_fire, bundle_free, advance;

  assign out_fire    = (cnt_q != 2'd0) && !out_stall_i;
  assign bundle_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  assign advance     = inq_valid_q && bundle_free;
  assign in_stall_o  = inq_valid_q && !bundle_free;
  assign in_fire     = in_valid_i && !in_stall_o;

  // Decode of the held request into new tokens and the next state.
  tok_t       new_tok [MaxTokens];
  logic [1:0] new_cnt;
  fresh_t     fr;
  esc_t       es;
  pos_t       p0, pm1, pm2;

  always_comb begin
    p0      = count_q;
    pm1     = count_q - PosBits'(1);
    pm2     = count_q - PosBits'(2);
    fr      = fresh_decode(inq_byte_q);
    es      = esc_decode(inq_byte_q);
    new_cnt = 2'd0;
    for (int i = 0; i < MaxTokens; i++) begin
      new_tok[i] = '{kind: KindEof, payload: 8'd0, pos: '0};
    end
    mode_d   = mode_q;
    halted_d = halted_q;
    count_d  = count_q;

    if (inq_op_q) begin
      // End of input: flush the held group, then eof, then restart.
      if (!halted_q) begin
        if (mode_q == PendParen) begin
          new_tok[0] = '{kind: KindLParen, payload: 8'd0, pos: pm1};
          new_cnt    = 2'd1;
        end else if (mode_q == PendQuest) begin
          new_tok[0] = '{kind: KindLParen, payload: 8'd0, pos: pm2};
          new_tok[1] = '{kind: KindQuestion, payload: 8'd0, pos: pm1};
          new_cnt    = 2'd2;
        end else if (mode_q == PendEscape) begin
          new_tok[0] = '{kind: KindErrTrail, payload: 8'd0, pos: pm1};
          new_cnt    = 2'd1;
        end
      end
      new_tok[new_cnt] = '{kind: KindEof, payload: 8'd0,
                           pos: (count_q == '0) ? '0 : pm1};
      new_cnt  = new_cnt + 2'd1;
      mode_d   = PendNone;
      halted_d = 1'b0;
      count_d  = '0;
    end else begin
      count_d = count_q + PosBits'(1);
      if (!halted_q) begin
        // A broken group is emitted before the byte is taken as a fresh one.
        mode_d = PendNone;
        if (mode_q == PendParen && inq_byte_q != ChQuestion) begin
          new_tok[0] = '{kind: KindLParen, payload: 8'd0, pos: pm1};
          new_cnt    = 2'd1;
        end else if (mode_q == PendQuest && inq_byte_q != ChColon) begin
          new_tok[0] = '{kind: KindLParen, payload: 8'd0, pos: pm2};
          new_tok[1] = '{kind: KindQuestion, payload: 8'd0, pos: pm1};
          new_cnt    = 2'd2;
        end

        if (mode_q == PendParen && inq_byte_q == ChQuestion) begin
          mode_d = PendQuest;
        end else if (mode_q == PendQuest && inq_byte_q == ChColon) begin
          new_tok[0] = '{kind: KindNcGroup, payload: 8'd0, pos: p0};
          new_cnt    = 2'd1;
        end else if (mode_q == PendEscape) begin
          new_tok[0] = '{kind: es.kind, payload: es.payload,
                         pos: es.halt ? pm1 : p0};
          new_cnt    = 2'd1;
          halted_d   = es.halt;
        end else begin
          mode_d   = fr.mode;
          halted_d = fr.halt;
          if (fr.emit) begin
            new_tok[new_cnt] = '{kind: fr.kind, payload: fr.payload, pos: p0};
            new_cnt          = new_cnt + 2'd1;
          end
        end
      end
    end
  end

  // Bundle load or drain.
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxTokens; i++) begin
      tok_d[i] = tok_q[i];
    end
    if (advance) begin
      cnt_d = new_cnt;
      for (int i = 0; i < MaxTokens; i++) begin
        tok_d[i] = new_tok[i];
      end
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
      for (int i = 0; i < MaxTokens - 1; i++) begin
        tok_d[i] = tok_q[i+1];
      end
    end
  end

  always_comb begin
    inq_valid_d = inq_valid_q;
    if (in_fire) begin
      inq_valid_d = 1'b1;
    end else if (advance) begin
      inq_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
      mode_q      <= PendNone;
      count_q     <= '0;
      halted_q    <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
      cnt_q       <= cnt_d;
      if (advance) begin
        mode_q   <= mode_d;
        count_q  <= count_d;
        halted_q <= halted_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_op_q   <= op_i;
      inq_byte_q <= pattern_byte_i;
    end
    for (int i = 0; i < MaxTokens; i++) begin
      tok_q[i] <= tok_d[i];
    end
  end

  // The bundle holds only one request's results, so its final slot is the last one.
  assign out_valid_o = (cnt_q != 2'd0);
  assign kind_o      = tok_q[0].kind;
  assign payload_o   = tok_q[0].payload;
  assign position_o  = OutPosBits'(tok_q[0].pos);
  assign last_o      = (cnt_q == 2'd1);

endmodule

`default_nettype wire

FILE: rtl/rpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "regex_pattern_tokenizer_defines.svh"

// Port-level checks on the tokenizer.
module rpt_checker
  import rpt_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [4:0]            kind_o,
  input wire logic [7:0]            payload_o,
  input wire logic [OutPosBits-1:0] position_o,
  input wire logic                  last_o
);

  // A stalled result stays offered.
  `RPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its fields.
  `RPT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(kind_o) && $stable(payload_o) && $stable(position_o) && $stable(last_o))

  // End of file always closes the results of its request.
  `RPT_ASSERT_NOW(a_eof_last, clk_i, rst_ni, out_valid_o && kind_o == KindEof, last_o)

  // An error that halts the tokenizer is the final result of its request.
  `RPT_ASSERT_NOW(a_err_last, clk_i, rst_ni, out_valid_o && (kind_o == KindErrEscape || kind_o == KindErrByte), last_o)

  // Only special and literal tokens carry a character.
  `RPT_ASSERT_NOW(a_payload_zero, clk_i, rst_ni, out_valid_o && kind_o != KindSpecial && kind_o != KindLiteral, payload_o == 8'd0)

endmodule

bind regex_pattern_tokenizer rpt_checker u_rpt_checker (.*);

`default_nettype wire
